// ===== src/rlcs_pkg.sv =====
// shared constants, codes and types for the rgb565 led column scanner
package rlcs_pkg;

  localparam int MAX_FRAMES  = 64;
  localparam int COLUMNS     = 8;
  localparam int STORE_DEPTH = MAX_FRAMES * COLUMNS;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int LIM_W       = SLOT_W + 1;
  localparam int COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int FRAME_W     = 6;
  localparam int DUTY_W      = 8;
  localparam int PIX_W       = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 8;
  localparam int SEL_W       = 8;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COLUMN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FRAME  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_LAST_FRAME = 2'd0;
  localparam logic [CFG_AW-1:0] REG_RED_FS     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_GREEN_FS   = 2'd2;
  localparam logic [CFG_AW-1:0] REG_BLUE_FS    = 2'd3;

  localparam logic [FRAME_W-1:0] LAST_FRAME_RST = 6'd0;
  localparam logic [DUTY_W-1:0]  RED_FS_RST     = 8'd130;
  localparam logic [DUTY_W-1:0]  GREEN_FS_RST   = 8'd150;
  localparam logic [DUTY_W-1:0]  BLUE_FS_RST    = 8'd150;

  localparam logic [PIX_W-1:0] RED_MASK   = 16'hF800;
  localparam logic [PIX_W-1:0] GREEN_MASK = 16'h07E0;
  localparam logic [PIX_W-1:0] BLUE_MASK  = 16'h001F;

  typedef struct packed {
    logic              start;
    logic [PIX_W-1:0]  pixel;
    logic [DUTY_W-1:0] gain_r;
    logic [DUTY_W-1:0] gain_g;
    logic [DUTY_W-1:0] gain_b;
  } scl_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] duty_r;
    logic [DUTY_W-1:0] duty_g;
    logic [DUTY_W-1:0] duty_b;
  } scl_rsp_t;

endpackage

// ===== src/rlcs_channels.sv =====
// valid/ready channel interfaces for input, result and configuration
interface rlcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [rlcs_pkg::MODE_W-1:0]   mode;
  logic [rlcs_pkg::PIX_W-1:0]    pixel_word;
  modport source (output valid, mode, pixel_word, input ready);
  modport sink (input valid, mode, pixel_word, output ready);
endinterface

interface rlcs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          drive_valid;
  logic [rlcs_pkg::DUTY_W-1:0]   red_duty;
  logic [rlcs_pkg::DUTY_W-1:0]   green_duty;
  logic [rlcs_pkg::DUTY_W-1:0]   blue_duty;
  logic [rlcs_pkg::SEL_W-1:0]    column_select;
  logic [rlcs_pkg::FRAME_W-1:0]  frame_index;
  modport source (output valid, drive_valid, red_duty, green_duty, blue_duty,
                  column_select, frame_index, input ready);
  modport sink (input valid, drive_valid, red_duty, green_duty, blue_duty,
                column_select, frame_index, output ready);
endinterface

interface rlcs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rlcs_pkg::CFG_AW-1:0]   addr;
  logic [rlcs_pkg::CFG_DW-1:0]   data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== src/rlcs_scaler.sv =====
// three-stage pipeline scaling rgb565 fields to pwm duties by exact floor division
module rlcs_scaler (
  input  logic               clk,
  input  logic               rst_n,
  input  rlcs_pkg::scl_req_t req,
  output rlcs_pkg::scl_rsp_t rsp
);

  // reciprocals: 1057/2^15 and 65/2^12 undershoot 1/31 and 1/63 by less than one step
  localparam logic [10:0] RECIP_31 = 11'd1057;
  localparam int          SHIFT_31 = 15;
  localparam logic [6:0]  RECIP_63 = 7'd65;
  localparam int          SHIFT_63 = 12;
  localparam logic [5:0]  DIV_31   = 6'd31;
  localparam logic [5:0]  DIV_63   = 6'd63;

  function automatic logic [7:0] fix_quot(input logic [13:0] p, input logic [7:0] q,
                                          input logic [5:0] d);
    logic [13:0] rem;
    rem = p - 14'(q * d);
    fix_quot = (rem >= 14'(d)) ? q + 8'd1 : q;
  endfunction

  logic [2:0]  vld_r;
  logic [12:0] pr_r, pb_r;
  logic [13:0] pg_r;
  logic [12:0] pr2_r, pb2_r;
  logic [13:0] pg2_r;
  logic [7:0]  qr_r, qg_r, qb_r;
  logic [7:0]  dr_r, dg_r, db_r;
  logic [23:0] er, eb;
  logic [20:0] eg;
  logic [4:0]  fr, fb;
  logic [5:0]  fg;

  assign fr = 5'((req.pixel & rlcs_pkg::RED_MASK) >> 11);
  assign fg = 6'((req.pixel & rlcs_pkg::GREEN_MASK) >> 5);
  assign fb = 5'(req.pixel & rlcs_pkg::BLUE_MASK);

  assign er = 24'(pr_r) * 24'(RECIP_31);
  assign eb = 24'(pb_r) * 24'(RECIP_31);
  assign eg = 21'(pg_r) * 21'(RECIP_63);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    pr_r  <= 13'(fr) * 13'(req.gain_r);
    pg_r  <= 14'(fg) * 14'(req.gain_g);
    pb_r  <= 13'(fb) * 13'(req.gain_b);
    pr2_r <= pr_r;
    pg2_r <= pg_r;
    pb2_r <= pb_r;
    qr_r  <= er[SHIFT_31+7:SHIFT_31];
    qg_r  <= eg[SHIFT_63+7:SHIFT_63];
    qb_r  <= eb[SHIFT_31+7:SHIFT_31];
    dr_r  <= fix_quot({1'b0, pr2_r}, qr_r, DIV_31);
    dg_r  <= fix_quot(pg2_r, qg_r, DIV_63);
    db_r  <= fix_quot({1'b0, pb2_r}, qb_r, DIV_31);
  end

  assign rsp.done   = vld_r[2];
  assign rsp.duty_r = dr_r;
  assign rsp.duty_g = dg_r;
  assign rsp.duty_b = db_r;

endmodule

// ===== src/rlcs_duty_ram.sv =====
// duty store: one write port, one read port with registered read data
module rlcs_duty_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [rlcs_pkg::SLOT_W-1:0]   waddr,
  input  logic [3*rlcs_pkg::DUTY_W-1:0] wdata,
  input  logic                          re,
  input  logic [rlcs_pkg::SLOT_W-1:0]   raddr,
  output logic [3*rlcs_pkg::DUTY_W-1:0] rdata
);

  logic [3*rlcs_pkg::DUTY_W-1:0] mem [rlcs_pkg::STORE_DEPTH];
  logic [3*rlcs_pkg::DUTY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rgb565_led_column_scanner.sv =====
// top level: sequencer, scan state and result register of the led column scanner
//
// in_ch takes requests with a mode and an rgb565 pixel; every request gives one
// result on out_ch. a load request scales the pixel to three pwm duties and writes
// them to the next slot of a frame-by-column duty store. a column request reads the
// current frame's duties for the current column from the store and returns them with
// a one-hot column select, then steps the column. a frame request steps the frame; it
// and unused modes return an all-zero result. one request is in work at a time, so a
// new request is taken only once the last one's result is in the output register.
// cfg_ch writes last_frame and the three full-scale gains and is always ready.
// after reset the gains are 130/150/150, last_frame is 0 and the store reads as zero:
// a fill count marks how far the store has been written since reset, so no clearing
// pass is needed. a result waits in the output register while the receiver stalls;
// the next request is still taken and holds in its final cycle until the register frees.
module rgb565_led_column_scanner (
  input  logic       clk,
  input  logic       rst_n,
  rlcs_in_if.sink    in_ch,
  rlcs_out_if.source out_ch,
  rlcs_cfg_if.sink   cfg_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;

  localparam int SW = rlcs_pkg::SLOT_W;
  localparam int LW = rlcs_pkg::LIM_W;
  localparam int CW = rlcs_pkg::COL_W;
  localparam int FW = rlcs_pkg::FRAME_W;
  localparam int DW = rlcs_pkg::DUTY_W;

  logic [2:0]    state_r, state_nxt;
  logic [FW-1:0] last_frame_r;
  logic [DW-1:0] gain_r_r, gain_g_r, gain_b_r;
  logic [SW-1:0] slot_r, slot_wr_r;
  logic [LW-1:0] fill_r;
  logic [CW-1:0] col_r;
  logic [FW-1:0] frame_r;

  logic          res_drive_r, rd_hit_r;
  logic [7:0]    res_sel_r;
  logic [FW-1:0] res_frame_r;

  logic          out_valid_r, out_drive_r;
  logic [DW-1:0] out_red_r, out_green_r, out_blue_r;
  logic [7:0]    out_sel_r;
  logic [FW-1:0] out_frame_r;

  rlcs_pkg::scl_req_t scl_req;
  rlcs_pkg::scl_rsp_t scl_rsp;

  logic            accept, put;
  logic [FW-1:0]   eff_last;
  logic [LW-1:0]   limit, slot_inc;
  logic [SW-1:0]   rd_idx;
  logic [7:0]      col_sel;
  logic [3*DW-1:0] rd_data;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign put = (state_r == S_PUT) && (!out_valid_r || out_ch.ready);

  assign eff_last = (LW'(last_frame_r) > LW'(rlcs_pkg::MAX_FRAMES - 1))
                    ? FW'(rlcs_pkg::MAX_FRAMES - 1) : last_frame_r;
  assign limit    = LW'((LW'(eff_last) + LW'(1)) * LW'(rlcs_pkg::COLUMNS));
  assign slot_inc = LW'(slot_wr_r) + LW'(1);
  assign rd_idx   = SW'(LW'(frame_r) * LW'(rlcs_pkg::COLUMNS) + LW'(col_r));

  // columns from 8 up have no select bit
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      col_sel[i] = (i < rlcs_pkg::COLUMNS) && (LW'(col_r) == LW'(i));
    end
  end

  assign scl_req.start  = accept && (in_ch.mode == rlcs_pkg::MODE_LOAD);
  assign scl_req.pixel  = in_ch.pixel_word;
  assign scl_req.gain_r = gain_r_r;
  assign scl_req.gain_g = gain_g_r;
  assign scl_req.gain_b = gain_b_r;

  rlcs_scaler u_scaler (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scl_req),
    .rsp   (scl_rsp)
  );

  rlcs_duty_ram u_ram (
    .clk   (clk),
    .we    (scl_rsp.done),
    .waddr (slot_wr_r),
    .wdata ({scl_rsp.duty_r, scl_rsp.duty_g, scl_rsp.duty_b}),
    .re    (accept && (in_ch.mode == rlcs_pkg::MODE_COLUMN)),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_ch.mode)
            rlcs_pkg::MODE_LOAD:   state_nxt = S_LOAD;
            rlcs_pkg::MODE_COLUMN: state_nxt = S_READ;
            default:               state_nxt = S_PUT;
          endcase
        end
      end
      S_LOAD: if (scl_rsp.done) state_nxt = S_PUT;
      S_READ: state_nxt = S_PUT;
      S_PUT:  if (put) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_frame_r <= rlcs_pkg::LAST_FRAME_RST;
      gain_r_r     <= rlcs_pkg::RED_FS_RST;
      gain_g_r     <= rlcs_pkg::GREEN_FS_RST;
      gain_b_r     <= rlcs_pkg::BLUE_FS_RST;
      slot_r       <= '0;
      fill_r       <= '0;
      col_r        <= '0;
      frame_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.addr)
          rlcs_pkg::REG_LAST_FRAME: last_frame_r <= FW'(cfg_ch.data);
          rlcs_pkg::REG_RED_FS:     gain_r_r     <= cfg_ch.data;
          rlcs_pkg::REG_GREEN_FS:   gain_g_r     <= cfg_ch.data;
          rlcs_pkg::REG_BLUE_FS:    gain_b_r     <= cfg_ch.data;
          default: ;
        endcase
      end
      if (accept && (in_ch.mode == rlcs_pkg::MODE_COLUMN)) begin
        col_r <= (LW'(col_r) == LW'(rlcs_pkg::COLUMNS - 1)) ? '0 : col_r + CW'(1);
      end
      if (accept && (in_ch.mode == rlcs_pkg::MODE_FRAME)) begin
        frame_r <= (frame_r >= eff_last) ? '0 : frame_r + FW'(1);
      end
      if (scl_rsp.done) begin
        slot_r <= (slot_inc >= limit) ? '0 : slot_inc[SW-1:0];
        // store entries below the fill count have been written since reset
        if (slot_inc > fill_r) begin
          fill_r <= slot_inc;
        end
      end
      if (put) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_wr_r   <= (LW'(slot_r) >= limit) ? '0 : slot_r;
      res_drive_r <= (in_ch.mode == rlcs_pkg::MODE_COLUMN);
      res_sel_r   <= col_sel;
      res_frame_r <= frame_r;
      rd_hit_r    <= LW'(rd_idx) < fill_r;
    end
    if (put) begin
      out_drive_r <= res_drive_r;
      out_sel_r   <= res_drive_r ? res_sel_r : '0;
      out_frame_r <= res_drive_r ? res_frame_r : '0;
      out_red_r   <= (res_drive_r && rd_hit_r) ? rd_data[3*DW-1:2*DW] : '0;
      out_green_r <= (res_drive_r && rd_hit_r) ? rd_data[2*DW-1:DW] : '0;
      out_blue_r  <= (res_drive_r && rd_hit_r) ? rd_data[DW-1:0] : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_valid   = out_drive_r;
  assign out_ch.red_duty      = out_red_r;
  assign out_ch.green_duty    = out_green_r;
  assign out_ch.blue_duty     = out_blue_r;
  assign out_ch.column_select = out_sel_r;
  assign out_ch.frame_index   = out_frame_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(rlcs_pkg::STORE_DEPTH))
    else $error("fill count past store depth");

  a_scaler_done_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    scl_rsp.done |-> state_r == S_LOAD)
    else $error("scaler result outside load sequence");

  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drive_r) |-> $onehot(out_sel_r))
    else $error("column select not one-hot on drive result");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_drive_r) |-> (out_sel_r == '0 && out_red_r == '0 &&
      out_green_r == '0 && out_blue_r == '0 && out_frame_r == '0))
    else $error("non-drive result carries payload");

endmodule
